### rtl/core/ksel_pkg.sv
`default_nettype none

package ksel_pkg;

  // Rank register width is fixed by the register map
  localparam int RANK_W = 7;

  // Read address selection for the heap store
  typedef enum logic [1:0] {
    RD_POP,
    RD_CHILD,
    RD_PARENT
  } rd_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic    capture;     // latch the incoming sample
    logic    pop_start;   // drop root: count--, fetch last entry
    logic    push_start;  // open a hole at the tail for the sample
    logic    repl_start;  // sample replaces the root
    logic    pop_load;    // fetched last entry becomes the sifting value
    logic    dn_step;     // one sift-down level, writes the hole
    logic    up_step;     // one sift-up level, writes the hole
    logic    up_root;     // sift-up reached the root
    logic    emit;        // load result register, empty the heap
    rd_sel_t rd_sel;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rank_ok;
    logic cnt_gt;
    logic cnt_lt;
    logic samp_lt_top;
    logic pos_zero;
    logic dn_stay;
    logic up_stay;
    logic last;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/ksel_if.sv
`default_nettype none

interface ksel_in_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample_value;
  logic                         last_of_set;

  modport source (output valid, sample_value, last_of_set, input ready);
  modport sink   (input valid, sample_value, last_of_set, output ready);
endinterface

interface ksel_out_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] kth_value;
  logic                         found;

  modport source (output valid, kth_value, found, input ready);
  modport sink   (input valid, kth_value, found, output ready);
endinterface

interface ksel_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] kth_rank;

  modport source (output valid, kth_rank, input ready);
  modport sink   (input valid, kth_rank, output ready);
endinterface

`default_nettype wire

### rtl/core/ksel_datapath.sv
`default_nettype none

module ksel_datapath
  import ksel_pkg::*;
#(
  parameter int K_MAX      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire dp_cmd_t                      cmd,
  output dp_stat_t                          stat,
  input  wire logic signed [DATA_WIDTH-1:0] sample_value,
  input  wire logic                         last_of_set,
  input  wire logic                         cfg_write,
  input  wire logic [RANK_W-1:0]            cfg_rank,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      kth_value,
  output logic                              found
);

  localparam int IDX_W  = $clog2(K_MAX + 1);
  localparam int ADDR_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int CMP_W  = (IDX_W > RANK_W) ? IDX_W : RANK_W;
  localparam int CH_W   = IDX_W + 1;

  logic signed [DATA_WIDTH-1:0] mem [K_MAX];

  logic [RANK_W-1:0]            rank;
  logic [IDX_W-1:0]             count;
  logic [IDX_W-1:0]             pos;
  logic signed [DATA_WIDTH-1:0] samp;
  logic signed [DATA_WIDTH-1:0] cur;
  logic signed [DATA_WIDTH-1:0] top;
  logic signed [DATA_WIDTH-1:0] rd_a;
  logic signed [DATA_WIDTH-1:0] rd_b;
  logic                         last_q;

  logic [CH_W-1:0]              left_idx;
  logic [CH_W-1:0]              right_idx;
  logic [IDX_W-1:0]             parent_idx;
  logic [IDX_W-1:0]             big_idx;
  logic [CMP_W-1:0]             count_w;
  logic [CMP_W-1:0]             rank_w;
  logic                         rank_ok;
  logic                         found_now;
  logic                         l_ok;
  logic                         r_ok;
  logic                         gt_l;
  logic                         gt_r;
  logic signed [DATA_WIDTH-1:0] lbig_val;
  logic signed [DATA_WIDTH-1:0] child_val;
  logic                         dn_stay;
  logic                         up_stay;

  logic [ADDR_W-1:0]            addr_a;
  logic [ADDR_W-1:0]            addr_b;
  logic                         wr_en;
  logic [ADDR_W-1:0]            wr_addr;
  logic signed [DATA_WIDTH-1:0] wr_data;

  // heap index arithmetic
  assign left_idx   = {pos, 1'b1};
  assign right_idx  = left_idx + CH_W'(1);
  assign parent_idx = IDX_W'((pos - IDX_W'(1)) >> 1);
  assign count_w    = CMP_W'(count);
  assign rank_w     = CMP_W'(rank);
  assign rank_ok    = (rank != '0) && (rank_w <= CMP_W'(K_MAX));
  assign found_now  = rank_ok && (count_w == rank_w);

  // sift-down compare: larger child wins only if strictly above the sifting value
  assign l_ok      = left_idx < CH_W'(count);
  assign r_ok      = right_idx < CH_W'(count);
  assign gt_l      = l_ok && (rd_a > cur);
  assign lbig_val  = gt_l ? rd_a : cur;
  assign gt_r      = r_ok && (rd_b > lbig_val);
  assign dn_stay   = !gt_l && !gt_r;
  assign child_val = gt_r ? rd_b : rd_a;
  assign big_idx   = gt_r ? IDX_W'(right_idx) : IDX_W'(left_idx);

  assign up_stay = rd_a >= cur;

  always_comb begin
    case (cmd.rd_sel)
      RD_POP:    addr_a = ADDR_W'(count - IDX_W'(1));
      RD_CHILD:  addr_a = ADDR_W'(left_idx);
      RD_PARENT: addr_a = ADDR_W'(parent_idx);
      default:   addr_a = '0;
    endcase
  end
  assign addr_b = ADDR_W'(right_idx);

  // hole write: the sifting value lives in cur until its final slot is known
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ADDR_W'(pos);
    wr_data = cur;
    if (cmd.dn_step) begin
      wr_en   = 1'b1;
      wr_data = dn_stay ? cur : child_val;
    end else if (cmd.up_step) begin
      wr_en   = 1'b1;
      wr_data = up_stay ? cur : rd_a;
    end else if (cmd.up_root) begin
      wr_en   = 1'b1;
      wr_data = cur;
    end
  end

  always_ff @(posedge clk) begin
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rank      <= RANK_W'(1);
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        rank <= cfg_rank;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.pop_start) begin
        count <= count - IDX_W'(1);
      end
      if (cmd.push_start) begin
        count <= count + IDX_W'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        count     <= '0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      samp   <= sample_value;
      last_q <= last_of_set;
    end
    if (cmd.push_start) begin
      pos <= count;
      cur <= samp;
    end
    if (cmd.repl_start) begin
      pos <= '0;
      cur <= samp;
    end
    if (cmd.pop_load) begin
      pos <= '0;
      cur <= rd_a;
    end
    if (cmd.dn_step && !dn_stay) begin
      pos <= big_idx;
    end
    if (cmd.up_step && !up_stay) begin
      pos <= parent_idx;
    end
    // root mirror
    if (wr_en && (pos == '0)) begin
      top <= wr_data;
    end
    if (cmd.emit) begin
      kth_value <= found_now ? top : '0;
      found     <= found_now;
    end
  end

  assign stat.rank_ok     = rank_ok;
  assign stat.cnt_gt      = count_w > rank_w;
  assign stat.cnt_lt      = count_w < rank_w;
  assign stat.samp_lt_top = samp < top;
  assign stat.pos_zero    = pos == '0;
  assign stat.dn_stay     = dn_stay;
  assign stat.up_stay     = up_stay;
  assign stat.last        = last_q;
  assign stat.out_busy    = out_valid && !out_ready;

endmodule

`default_nettype wire

### rtl/core/ksel_ctrl.sv
`default_nettype none

module ksel_ctrl
  import ksel_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_POP_LOAD,
    S_DN_READ,
    S_DN_CMP,
    S_UP_READ,
    S_UP_CMP,
    S_FINISH
  } state_t;

  state_t state;
  logic   popping;

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_CHILD;
    unique case (state)
      S_IDLE: begin
        cmd.capture = in_valid && in_ready;
      end
      S_DECIDE: begin
        if (stat.rank_ok && stat.cnt_gt) begin
          cmd.pop_start = 1'b1;
          cmd.rd_sel    = RD_POP;
        end else if (stat.rank_ok && stat.cnt_lt) begin
          cmd.push_start = 1'b1;
        end else if (stat.rank_ok && stat.samp_lt_top) begin
          cmd.repl_start = 1'b1;
        end
      end
      S_POP_LOAD: begin
        cmd.pop_load = 1'b1;
      end
      S_DN_READ: begin
        cmd.rd_sel = RD_CHILD;
      end
      S_DN_CMP: begin
        cmd.dn_step = 1'b1;
      end
      S_UP_READ: begin
        if (stat.pos_zero) begin
          cmd.up_root = 1'b1;
        end else begin
          cmd.rd_sel = RD_PARENT;
        end
      end
      S_UP_CMP: begin
        cmd.up_step = 1'b1;
      end
      S_FINISH: begin
        cmd.emit = stat.last && !stat.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
      popping  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= S_DECIDE;
            in_ready <= 1'b0;
          end
        end
        S_DECIDE: begin
          if (!stat.rank_ok) begin
            state <= S_FINISH;
          end else if (stat.cnt_gt) begin
            state   <= S_POP_LOAD;
            popping <= 1'b1;
          end else if (stat.cnt_lt) begin
            state <= S_UP_READ;
          end else if (stat.samp_lt_top) begin
            state   <= S_DN_READ;
            popping <= 1'b0;
          end else begin
            state <= S_FINISH;
          end
        end
        S_POP_LOAD: begin
          state <= S_DN_READ;
        end
        S_DN_READ: begin
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (stat.dn_stay) begin
            // after a pop the rank check runs again
            state <= popping ? S_DECIDE : S_FINISH;
          end else begin
            state <= S_DN_READ;
          end
        end
        S_UP_READ: begin
          state <= stat.pos_zero ? S_FINISH : S_UP_CMP;
        end
        S_UP_CMP: begin
          state <= stat.up_stay ? S_FINISH : S_UP_READ;
        end
        S_FINISH: begin
          if (!stat.last || !stat.out_busy) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/kth_smallest_selector.sv
// Channel   Modport  Transfer carries
// --------  -------  ---------------------------------------------
// samples   sink     sample_value, last_of_set
// results   source   kth_value, found (one per set, on its last item)
// cfg       sink     kth_rank (always ready)
//
// One item at a time: idle accepts it, decide picks a path, finish ends it.
// Between them a push reads and compares one parent per level climbed, up to
// the root; a replace reads and compares the children per level descended.
// A level has a read and a compare state: the heap store read is registered.
// Each entry dropped after a rank cut adds a pop load and a sift-down.
// Reset (rst, synchronous) empties the heap, rank 1; a waiting result stalls
// only the next set's end.
`default_nettype none

module kth_smallest_selector
  import ksel_pkg::*;
#(
  parameter int K_MAX      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ksel_in_if.sink    samples,
  ksel_out_if.source results,
  ksel_cfg_if.sink   cfg
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  // rank writes land straight in the datapath register
  assign cfg.ready     = 1'b1;
  assign samples.ready = in_ready;

  ksel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // heap store, index arithmetic, root mirror and result register
  ksel_datapath #(
    .K_MAX      (K_MAX),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample_value (samples.sample_value),
    .last_of_set  (samples.last_of_set),
    .cfg_write    (cfg.valid),
    .cfg_rank     (cfg.kth_rank),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .kth_value    (results.kth_value),
    .found        (results.found)
  );

endmodule

`default_nettype wire
